// File: rtl/core/assert_macros.svh
// Assertion helpers for the checker file gzmd_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define GZMD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define GZMD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/gzmd_pkg.sv
// ----------------------------------------------------------------------------
// gzmd_pkg
// Codes, result types and section selection for the gzip member deframer.
// ----------------------------------------------------------------------------
package gzmd_pkg;

  localparam logic [7:0] MagicA    = 8'h1F;
  localparam logic [7:0] MagicB    = 8'h8B;
  localparam logic [7:0] MethodDef = 8'h08;
  localparam int unsigned FlHcrc    = 1;
  localparam int unsigned FlExtra   = 2;
  localparam int unsigned FlName    = 3;
  localparam int unsigned FlComment = 4;
  localparam logic [15:0] FixedSkip = 16'd6;   // fixed header bytes after FLG
  localparam logic [4:0]  MinTotal  = 5'd18;
  localparam int unsigned DelayLen  = 8;
  localparam int unsigned FifoDepth = 4;

  localparam logic [3:0] PH_ID1     = 4'd0;
  localparam logic [3:0] PH_ID2     = 4'd1;
  localparam logic [3:0] PH_CM      = 4'd2;
  localparam logic [3:0] PH_FLG     = 4'd3;
  localparam logic [3:0] PH_FIXED   = 4'd4;
  localparam logic [3:0] PH_XLEN0   = 4'd5;
  localparam logic [3:0] PH_XLEN1   = 4'd6;
  localparam logic [3:0] PH_EXTRA   = 4'd7;
  localparam logic [3:0] PH_NAME    = 4'd8;
  localparam logic [3:0] PH_COMMENT = 4'd9;
  localparam logic [3:0] PH_HCRC    = 4'd10;
  localparam logic [3:0] PH_PAYLOAD = 4'd11;
  localparam logic [3:0] PH_DISCARD = 4'd12;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_MAGIC  = 3'd2;
  localparam logic [2:0] ST_METHOD = 3'd3;
  localparam logic [2:0] ST_TRUNC  = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPORT  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [31:0] original_size;
    logic        run_end;
  } gzmd_result_t;

  typedef struct packed {
    logic [1:0]   count;   // results in this request: 0, 1 or 2
    gzmd_result_t r0;
    gzmd_result_t r1;
  } gzmd_push_t;

  // First optional section at or after 'from' that the flags ask for.
  function automatic logic [3:0] next_section(logic [7:0] flags, logic [3:0] from);
    logic [3:0] ph;
    if (from <= PH_XLEN0 && flags[FlExtra]) ph = PH_XLEN0;
    else if (from <= PH_NAME && flags[FlName]) ph = PH_NAME;
    else if (from <= PH_COMMENT && flags[FlComment]) ph = PH_COMMENT;
    else if (from <= PH_HCRC && flags[FlHcrc]) ph = PH_HCRC;
    else ph = PH_PAYLOAD;
    return ph;
  endfunction

endpackage

// File: rtl/core/gzmd_parser.sv
// ----------------------------------------------------------------------------
// gzmd_parser
// Header walk, trailer delay line and end report, one byte per cycle while step_i is high.
// ----------------------------------------------------------------------------
module gzmd_parser import gzmd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       fin_i,
  output gzmd_push_t push_o
);

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] skip_q, skip_d;
  logic [4:0]  total_q, total_d;
  logic [7:0]  tail_q [DelayLen];
  logic [7:0]  tail_d [DelayLen];
  logic [3:0]  fill_q, fill_d;
  logic [2:0]  err_q, err_d;

  always_comb begin
    gzmd_result_t pay, rep;
    logic         has_pay;
    logic [15:0]  skip_dec;
    logic [2:0]   st;

    phase_d  = phase_q;
    flags_d  = flags_q;
    skip_d   = skip_q;
    err_d    = err_q;
    fill_d   = fill_q;
    tail_d   = tail_q;
    has_pay  = 1'b0;
    skip_dec = skip_q - 16'd1;
    total_d  = (total_q < MinTotal) ? total_q + 5'd1 : total_q;

    pay = '0;
    pay.kind = KIND_PAYLOAD;
    pay.payload_byte = tail_q[0];
    pay.run_end = !fin_i;

    case (phase_q)
      PH_ID1: begin
        if (byte_i == MagicA) phase_d = PH_ID2;
        else begin
          err_d = ST_MAGIC;
          phase_d = PH_DISCARD;
        end
      end
      PH_ID2: begin
        if (byte_i == MagicB) phase_d = PH_CM;
        else begin
          err_d = ST_MAGIC;
          phase_d = PH_DISCARD;
        end
      end
      PH_CM: begin
        if (byte_i == MethodDef) phase_d = PH_FLG;
        else begin
          err_d = ST_METHOD;
          phase_d = PH_DISCARD;
        end
      end
      PH_FLG: begin
        flags_d = byte_i;
        skip_d  = FixedSkip;
        phase_d = PH_FIXED;
      end
      PH_FIXED: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = next_section(flags_q, PH_XLEN0);
      end
      PH_XLEN0: begin
        skip_d  = {8'h00, byte_i};
        phase_d = PH_XLEN1;
      end
      PH_XLEN1: begin
        skip_d  = {byte_i, skip_q[7:0]};
        phase_d = ({byte_i, skip_q[7:0]} != '0) ? PH_EXTRA
                                               : next_section(flags_q, PH_NAME);
      end
      PH_EXTRA: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = next_section(flags_q, PH_NAME);
      end
      PH_NAME: begin
        if (byte_i == 8'h00) phase_d = next_section(flags_q, PH_COMMENT);
      end
      PH_COMMENT: begin
        if (byte_i == 8'h00) phase_d = next_section(flags_q, PH_HCRC);
      end
      PH_HCRC: begin
        skip_d = skip_dec;
        if (skip_dec == '0) phase_d = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (fill_q[3]) begin
          has_pay = 1'b1;
          for (int i = 0; i < DelayLen - 1; i++) tail_d[i] = tail_q[i+1];
          tail_d[DelayLen-1] = byte_i;
        end else begin
          tail_d[fill_q[2:0]] = byte_i;
          fill_d = fill_q + 4'd1;
        end
      end
      default: phase_d = PH_DISCARD;
    endcase

    // header CRC always skips two bytes, whichever section led to it
    if (phase_d == PH_HCRC && phase_q != PH_HCRC) skip_d = 16'd2;

    if (total_d < MinTotal) st = ST_SHORT;
    else if (err_d != ST_OK) st = err_d;
    else if (phase_d != PH_PAYLOAD || !fill_d[3]) st = ST_TRUNC;
    else st = ST_OK;

    rep = '0;
    rep.kind = KIND_REPORT;
    rep.status = st;
    rep.run_end = 1'b1;
    if (st == ST_OK) rep.original_size = {tail_d[7], tail_d[6], tail_d[5], tail_d[4]};

    push_o = '0;
    if (step_i) begin
      if (has_pay && fin_i) begin
        push_o.count = 2'd2;
        push_o.r0 = pay;
        push_o.r1 = rep;
      end else if (has_pay) begin
        push_o.count = 2'd1;
        push_o.r0 = pay;
      end else if (fin_i) begin
        push_o.count = 2'd1;
        push_o.r0 = rep;
      end
    end

    // end of file: back to reset values for the next member
    if (fin_i) begin
      phase_d = PH_ID1;
      flags_d = '0;
      skip_d  = '0;
      total_d = '0;
      fill_d  = '0;
      err_d   = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID1;
      flags_q <= '0;
      skip_q  <= '0;
      total_q <= '0;
      fill_q  <= '0;
      err_q   <= ST_OK;
    end else if (step_i) begin
      phase_q <= phase_d;
      flags_q <= flags_d;
      skip_q  <= skip_d;
      total_q <= total_d;
      fill_q  <= fill_d;
      err_q   <= err_d;
    end
  end

  // entries are read only after all eight were written, so no reset needed
  always_ff @(posedge clk_i) begin
    if (step_i) tail_q <= tail_d;
  end

endmodule

// File: rtl/core/gzmd_out_fifo.sv
// ----------------------------------------------------------------------------
// gzmd_out_fifo
// Small result queue: up to two entries in per cycle, one out.
// ----------------------------------------------------------------------------
module gzmd_out_fifo import gzmd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  gzmd_push_t   push_i,
  input  logic         pop_i,
  output logic         valid_o,
  output logic         room_o,
  output gzmd_result_t head_o
);

  localparam int unsigned PtrW = $clog2(FifoDepth);
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  gzmd_result_t    mem_q [FifoDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_next;

  assign wr_next = wr_q + PtrW'(1);
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CntW'(FifoDepth - 2));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.count);
    rd_d  = pop_i ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.r0;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.r1;
  end

endmodule

// File: rtl/core/gzip_member_deframer_top.sv
// ----------------------------------------------------------------------------
// gzip_member_deframer_top
// Strips gzip member headers and emits deflate payload plus an end report.
// ----------------------------------------------------------------------------
// Input: one file byte per item on s_axis, tlast on the final byte of a file.
// Output: m_axis items; tuser 0 is a payload byte, tuser 1 the end report
// carrying status and original size. tlast marks the last result of a byte.
// Payload lags the input by eight bytes, since the last eight are trailer.
// A byte is registered on entry and processed once the result queue has room,
// and its results are written to the queue, which presents them on m_axis.
// One byte per cycle is taken sustained while the receiver keeps taking
// results; the final byte makes two results, and the four-entry result
// queue absorbs that extra one. Input ready drops only when the queue
// lacks room for two results, i.e. when the receiver stalls.
// Reset clears the header walker and empties the queue; the next byte starts
// a new file. After each end report the walker also starts a new file.
// If the status is not ok, payload already sent belongs to a bad file.
// ----------------------------------------------------------------------------
module gzip_member_deframer_top import gzmd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // [7:0] payload_byte, [10:8] status,
                                        // [42:11] original_size, [47:43] zero
  output logic        m_axis_tuser_o,   // kind
  output logic        m_axis_tlast_o    // run_end
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_fin_q;
  logic         step;
  logic         room;
  gzmd_push_t   push;
  gzmd_result_t head;

  assign step            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_fin_q  <= s_axis_tlast_i;
    end
  end

  gzmd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .fin_i  (in_fin_q),
    .push_o (push)
  );

  gzmd_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_axis_tvalid_o && m_axis_tready_i),
    .valid_o (m_axis_tvalid_o),
    .room_o  (room),
    .head_o  (head)
  );

  assign m_axis_tdata_o = {5'b0, head.original_size, head.status, head.payload_byte};
  assign m_axis_tuser_o = head.kind;
  assign m_axis_tlast_o = head.run_end;

endmodule

// File: rtl/core/gzmd_checker.sv
// ----------------------------------------------------------------------------
// gzmd_checker
// Port-level checks on the deframer's result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gzmd_checker import gzmd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  `GZMD_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "result during reset")
  `GZMD_ASSERT(a_hold,
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o),
    "stalled result changed")
  `GZMD_ASSERT(a_report_last,
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && m_axis_tdata_o[7:0] == 8'h00,
    "bad end report framing")
  `GZMD_ASSERT(a_payload_clean,
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[47:8] == '0,
    "payload carries report fields")
  `GZMD_ASSERT(a_size_ok_only,
    m_axis_tvalid_o && m_axis_tdata_o[10:8] != ST_OK |->
      m_axis_tdata_o[47:11] == '0 && m_axis_tdata_o[10:8] <= ST_TRUNC,
    "bad status or size")

endmodule

bind gzip_member_deframer_top gzmd_checker u_gzmd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
